### sv/hti_pkg.sv
// Package with shared types and constants of the heightfield interpolator.
`timescale 1ns / 1ps
package hti_pkg;
  localparam int unsigned GridPoints = 128;
  localparam int unsigned IdxW = $clog2(GridPoints);
  localparam int unsigned AddrW = 2 * IdxW;
  // Width of the divider dividend: offsets are non-negative values of 33 bits.
  localparam int unsigned DivW = 33;
  localparam int unsigned FracW = 16;

  typedef enum logic [1:0] {
    RegOriginX = 2'd0,
    RegOriginZ = 2'd1,
    RegCellSize = 2'd2,
    RegPoints = 2'd3
  } reg_idx_e;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqQuery = 1'b1;
endpackage

### sv/hti_divider.sv
// Pipelined restoring divider: one quotient bit per stage, then the fraction bits.
`timescale 1ns / 1ps
module hti_divider
  import hti_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [DivW-1:0]   dx_i,
  input  logic [DivW-1:0]   dz_i,
  input  logic [30:0]       cs_i,
  input  logic [IdxW:0]     lim_i,
  input  logic              out_i,
  output logic              valid_o,
  output logic              out_o,
  output logic [IdxW-1:0]   gx_o,
  output logic [IdxW-1:0]   gz_o,
  output logic [FracW-1:0]  fx_o,
  output logic [FracW-1:0]  fz_o
);
  // Quotient bits plus fraction bits.
  localparam int unsigned Steps = DivW + FracW;

  logic [Steps:0]           v_q;
  logic [Steps:0]           o_q;
  logic [30:0]              cs_q [Steps+1];
  logic [IdxW:0]            lim_q [Steps+1];
  logic [DivW+FracW-1:0]    nx_q [Steps+1];
  logic [DivW+FracW-1:0]    nz_q [Steps+1];
  logic [31:0]              rx_q [Steps+1];
  logic [31:0]              rz_q [Steps+1];
  logic [Steps-1:0]         qx_q [Steps+1];
  logic [Steps-1:0]         qz_q [Steps+1];

  // Stage 0 loads the dividends, shifted to carry the fraction bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    o_q[0]   <= out_i;
    cs_q[0]  <= cs_i;
    lim_q[0] <= lim_i;
    nx_q[0]  <= {dx_i, {FracW{1'b0}}};
    nz_q[0]  <= {dz_i, {FracW{1'b0}}};
    rx_q[0]  <= '0;
    rz_q[0]  <= '0;
    qx_q[0]  <= '0;
    qz_q[0]  <= '0;
  end

  // One shift, compare and subtract per stage for each axis.
  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [32:0] tx, tz;
    logic        gex, gez;
    assign tx  = {rx_q[s], nx_q[s][DivW+FracW-1]};
    assign tz  = {rz_q[s], nz_q[s][DivW+FracW-1]};
    assign gex = tx >= {2'b00, cs_q[s]};
    assign gez = tz >= {2'b00, cs_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      o_q[s+1]   <= o_q[s];
      cs_q[s+1]  <= cs_q[s];
      lim_q[s+1] <= lim_q[s];
      nx_q[s+1]  <= {nx_q[s][DivW+FracW-2:0], 1'b0};
      nz_q[s+1]  <= {nz_q[s][DivW+FracW-2:0], 1'b0};
      rx_q[s+1]  <= gex ? 32'(tx - {2'b00, cs_q[s]}) : tx[31:0];
      rz_q[s+1]  <= gez ? 32'(tz - {2'b00, cs_q[s]}) : tz[31:0];
      qx_q[s+1]  <= {qx_q[s][Steps-2:0], gex};
      qz_q[s+1]  <= {qz_q[s][Steps-2:0], gez};
    end
  end

  // Split the quotient into cell index and fraction; range check the index.
  logic [DivW-1:0] gxf, gzf;
  assign gxf = qx_q[Steps][Steps-1:FracW];
  assign gzf = qz_q[Steps][Steps-1:FracW];

  assign valid_o = v_q[Steps];
  assign out_o   = o_q[Steps]
                 || (gxf >= DivW'(lim_q[Steps]))
                 || (gzf >= DivW'(lim_q[Steps]));
  assign gx_o    = gxf[IdxW-1:0];
  assign gz_o    = gzf[IdxW-1:0];
  assign fx_o    = qx_q[Steps][FracW-1:0];
  assign fz_o    = qz_q[Steps][FracW-1:0];
endmodule

### sv/heightfield_triangle_interpolator.sv
// Top level of the heightfield interpolator: config, height banks, blend pipeline.
`timescale 1ns / 1ps
// Pipeline: a query passes a divider of 50 register stages, a bank read, a weight stage,
// a multiply stage and a sum/round stage before strobe_o rises.
// Height writes give no result; they pass a delay line matching the divider to the banks.
// Throughput: one transaction per cycle; busy_o stays low, and the receiver cannot stall.
// Reset: config and valid registers reset to defaults; banks are undefined until written.
module heightfield_triangle_interpolator
  import hti_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              req_type_i,
  input  logic signed [31:0] query_x_i,
  input  logic signed [31:0] query_z_i,
  input  logic [6:0]        write_col_i,
  input  logic [6:0]        write_row_i,
  input  logic signed [31:0] write_height_i,
  output logic              strobe_o,
  output logic signed [31:0] height_o,
  output logic              outside_o
);
  // Configuration registers.
  logic [31:0] origin_x_q, origin_z_q;
  logic [30:0] cell_size_q;
  logic [7:0]  points_q;
  reg_idx_e    ridx;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign ridx   = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_z_q  <= '0;
      cell_size_q <= 31'd65536;
      points_q    <= 8'd128;
    end else if (wr_en) begin
      unique case (ridx)
        RegOriginX:  origin_x_q  <= pwdata;
        RegOriginZ:  origin_z_q  <= pwdata;
        RegCellSize: cell_size_q <= pwdata[30:0];
        RegPoints:   points_q    <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegOriginX:  prdata = origin_x_q;
      RegOriginZ:  prdata = origin_z_q;
      RegCellSize: prdata = {1'b0, cell_size_q};
      RegPoints:   prdata = {24'd0, points_q};
      default:     prdata = '0;
    endcase
  end

  // Entry stage: offsets, effective cell size and point count.
  logic              acc, qry;
  logic [32:0]       dx, dz;
  logic [30:0]       cs_eff;
  logic [7:0]        pts_eff;
  logic [IdxW:0]     lim;
  logic              pre_out;

  assign acc     = start_i && !busy_o;
  assign qry     = acc && (req_type_i == ReqQuery);
  assign dx      = 33'({query_x_i[31], query_x_i}) - 33'({origin_x_q[31], origin_x_q});
  assign dz      = 33'({query_z_i[31], query_z_i}) - 33'({origin_z_q[31], origin_z_q});
  assign cs_eff  = (cell_size_q == '0) ? 31'd1 : cell_size_q;
  assign pts_eff = (points_q > 8'(GridPoints)) ? 8'(GridPoints) : points_q;
  assign lim     = (IdxW+1)'(pts_eff - 8'd1);
  assign pre_out = (points_q < 8'd2) || dx[32] || dz[32];

  logic              dv;
  logic              dout;
  logic [IdxW-1:0]   gx, gz;
  logic [FracW-1:0]  fx, fz;

  hti_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (qry),
    .dx_i    (pre_out ? '0 : dx),
    .dz_i    (pre_out ? '0 : dz),
    .cs_i    (cs_eff),
    .lim_i   (lim),
    .out_i   (pre_out),
    .valid_o (dv),
    .out_o   (dout),
    .gx_o    (gx),
    .gz_o    (gz),
    .fx_o    (fx),
    .fz_o    (fz)
  );

  // Four banks by column and row parity, so the four corners are one read each.
  localparam int unsigned HalfW = IdxW - 1;
  localparam int unsigned BankD = GridPoints * GridPoints / 4;
  logic [31:0] bank00 [BankD];
  logic [31:0] bank10 [BankD];
  logic [31:0] bank01 [BankD];
  logic [31:0] bank11 [BankD];

  // Writes travel as long as a query needs to reach the bank read, so both keep their order.
  localparam int unsigned WrDelay = DivW + FracW + 1;
  logic               wen;
  logic [WrDelay-1:0] wv_q;
  logic [IdxW-1:0]    wcol_q [WrDelay];
  logic [IdxW-1:0]    wrow_q [WrDelay];
  logic [31:0]        wh_q [WrDelay];

  assign wen = acc && (req_type_i == ReqWrite);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= '0;
    end else begin
      wv_q <= {wv_q[WrDelay-2:0], wen};
    end
  end

  always_ff @(posedge clk_i) begin
    wcol_q[0] <= write_col_i;
    wrow_q[0] <= write_row_i;
    wh_q[0]   <= write_height_i;
    for (int i = 1; i < WrDelay; i++) begin
      wcol_q[i] <= wcol_q[i-1];
      wrow_q[i] <= wrow_q[i-1];
      wh_q[i]   <= wh_q[i-1];
    end
  end

  logic [2*HalfW-1:0] waddr;
  logic               wv;
  logic [IdxW-1:0]    wcol, wrow;
  logic [31:0]        wdat;
  assign wv    = wv_q[WrDelay-1];
  assign wcol  = wcol_q[WrDelay-1];
  assign wrow  = wrow_q[WrDelay-1];
  assign wdat  = wh_q[WrDelay-1];
  assign waddr = {wrow[IdxW-1:1], wcol[IdxW-1:1]};

  always_ff @(posedge clk_i) begin
    if (wv && !wcol[0] && !wrow[0]) bank00[waddr] <= wdat;
    if (wv &&  wcol[0] && !wrow[0]) bank10[waddr] <= wdat;
    if (wv && !wcol[0] &&  wrow[0]) bank01[waddr] <= wdat;
    if (wv &&  wcol[0] &&  wrow[0]) bank11[waddr] <= wdat;
  end

  // Per bank, the column and row of the corner that lands in it.
  logic [IdxW-1:0] gx1, gz1;
  logic [IdxW-1:0] ce, co, re, ro;
  assign gx1 = gx + 1'b1;
  assign gz1 = gz + 1'b1;
  assign ce  = gx[0] ? gx1 : gx;
  assign co  = gx[0] ? gx : gx1;
  assign re  = gz[0] ? gz1 : gz;
  assign ro  = gz[0] ? gz : gz1;

  logic [31:0]       rd00_q, rd10_q, rd01_q, rd11_q;
  logic              v1_q, o1_q, sx1_q, sz1_q;
  logic [FracW-1:0]  fx1_q, fz1_q;

  always_ff @(posedge clk_i) begin
    rd00_q <= bank00[{re[IdxW-1:1], ce[IdxW-1:1]}];
    rd10_q <= bank10[{re[IdxW-1:1], co[IdxW-1:1]}];
    rd01_q <= bank01[{ro[IdxW-1:1], ce[IdxW-1:1]}];
    rd11_q <= bank11[{ro[IdxW-1:1], co[IdxW-1:1]}];
    o1_q   <= dout;
    sx1_q  <= gx[0];
    sz1_q  <= gz[0];
    fx1_q  <= fx;
    fz1_q  <= fz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= dv;
    end
  end

  // Unswap corners by parity, pick the triangle and form the weights.
  logic [31:0] hl0, hl1, hu0, hu1;
  logic [31:0] h00, h10, h01, h11;
  logic [17:0] tot;
  logic        upper;
  logic signed [31:0] ha, hb, hc;
  logic [16:0] wa, wb, wc;

  always_comb begin
    hl0 = sx1_q ? rd10_q : rd00_q;
    hl1 = sx1_q ? rd00_q : rd10_q;
    hu0 = sx1_q ? rd11_q : rd01_q;
    hu1 = sx1_q ? rd01_q : rd11_q;
    h00 = sz1_q ? hu0 : hl0;
    h10 = sz1_q ? hu1 : hl1;
    h01 = sz1_q ? hl0 : hu0;
    h11 = sz1_q ? hl1 : hu1;
    tot = 18'(fx1_q) + 18'(fz1_q);
    upper = tot > 18'd65536;
    if (upper) begin
      ha = h10; wa = 17'(18'd65536 - 18'(fz1_q));
      hb = h11; wb = 17'(tot - 18'd65536);
      hc = h01; wc = 17'(18'd65536 - 18'(fx1_q));
    end else begin
      ha = h00; wa = 17'(18'd65536 - tot);
      hb = h10; wb = 17'(fx1_q);
      hc = h01; wc = 17'(fz1_q);
    end
  end

  logic signed [31:0] ha_q, hb_q, hc_q;
  logic [16:0]        wa_q, wb_q, wc_q;
  logic               v2_q, o2_q;

  always_ff @(posedge clk_i) begin
    ha_q <= ha; hb_q <= hb; hc_q <= hc;
    wa_q <= wa; wb_q <= wb; wc_q <= wc;
    o2_q <= o1_q;
  end

  // Three 32x17 products, registered.
  logic signed [49:0] pa_q, pb_q, pc_q;
  logic               v3_q, o3_q;

  always_ff @(posedge clk_i) begin
    pa_q <= ha_q * $signed({1'b0, wa_q});
    pb_q <= hb_q * $signed({1'b0, wb_q});
    pc_q <= hc_q * $signed({1'b0, wc_q});
    o3_q <= o2_q;
  end

  // Sum, round to nearest with ties up, and register the result.
  logic signed [51:0] sum;
  assign sum = 52'(pa_q) + 52'(pb_q) + 52'(pc_q) + 52'sd32768;

  logic [31:0] h_q;
  logic        o4_q, v4_q;

  always_ff @(posedge clk_i) begin
    h_q  <= o3_q ? 32'd0 : sum[47:16];
    o4_q <= o3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign strobe_o  = v4_q;
  assign height_o  = h_q;
  assign outside_o = o4_q;
endmodule

### sv/hti_checker.sv
// Port-level checker for the heightfield interpolator, bound to the top level.
`timescale 1ns / 1ps
module hti_checker
  import hti_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic        pready,
  input  logic        strobe_o,
  input  logic [31:0] height_o,
  input  logic        outside_o
);
  // An outside result always carries a zero height.
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && outside_o |-> height_o == 32'd0)
    else $error("outside result with nonzero height");

  // The block never holds off a transaction.
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("busy while a transaction is offered");

  // The configuration port completes in every access cycle.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // No result may appear at the clock edge where reset release is first seen.
  a_reset_quiet: assert property (@(posedge clk_i) $rose(rst_ni) |-> !strobe_o)
    else $error("result right after reset");
endmodule

bind heightfield_triangle_interpolator hti_checker u_hti_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .pready    (pready),
  .strobe_o  (strobe_o),
  .height_o  (height_o),
  .outside_o (outside_o)
);

### tb/sv/heightfield_triangle_interpolator_test.sv
// Testbench of the heightfield interpolator: directed table, then random phases.
`timescale 1ns / 1ps
module heightfield_triangle_interpolator_test;
  import hti_pkg::*;

  localparam int unsigned Latency = 56;
  localparam int unsigned SettleCycles = Latency + 8;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned ItemsPerPhase = 85;

  // One input transaction.
  typedef struct {
    logic        req;
    logic [31:0] qx;
    logic [31:0] qz;
    logic [6:0]  col;
    logic [6:0]  row;
    logic [31:0] h;
  } request_t;

  // One row of the directed table; typed_exp selects the typed-in answer.
  typedef struct {
    logic        req;
    logic [31:0] qx;
    logic [31:0] qz;
    logic [6:0]  col;
    logic [6:0]  row;
    logic [31:0] h;
    logic        typed_exp;
    logic [31:0] exp_height;
    logic        exp_outside;
  } table_row_t;

  typedef struct {
    logic [31:0] height;
    logic        outside;
  } answer_t;

  typedef struct {
    logic [31:0] height;
    logic        outside;
    int          gx;
    int          gz;
  } lookup_t;

  typedef struct {
    logic [31:0] ox;
    logic [31:0] oz;
    logic [31:0] cs;
    logic [31:0] pts;
  } setting_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start_i = 1'b0;
  logic busy_o;
  logic req_type_i = ReqWrite;
  logic signed [31:0] query_x_i = '0;
  logic signed [31:0] query_z_i = '0;
  logic [6:0] write_col_i = '0;
  logic [6:0] write_row_i = '0;
  logic signed [31:0] write_height_i = '0;
  logic strobe_o;
  logic signed [31:0] height_o;
  logic outside_o;

  heightfield_triangle_interpolator i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start_i, .busy_o, .req_type_i, .query_x_i, .query_z_i, .write_col_i,
    .write_row_i, .write_height_i, .strobe_o, .height_o, .outside_o
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the block's configuration and height grid.
  logic [31:0] origin_x_q = '0;
  logic [31:0] origin_z_q = '0;
  logic [30:0] cell_size_q = 31'd65536;
  logic [7:0]  points_q = 8'd128;
  logic [31:0] height_grid [GridPoints][GridPoints];
  bit          loaded [GridPoints][GridPoints];

  answer_t pending_heights[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit no_gaps = 0;

  // Barycentric height lookup on the shadow grid.
  function automatic lookup_t lookup_height(logic [31:0] qx, logic [31:0] qz);
    lookup_t r;
    longint dx, dz, cs, pts, gx, gz, fx, fz, tot, s;
    longint h00, h10, h01, h11;
    r.height = '0;
    r.outside = 1'b1;
    r.gx = 0;
    r.gz = 0;
    cs = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
    pts = (points_q > GridPoints) ? GridPoints : longint'(points_q);
    if (pts < 2) return r;
    dx = longint'($signed(qx)) - longint'($signed(origin_x_q));
    dz = longint'($signed(qz)) - longint'($signed(origin_z_q));
    if (dx < 0 || dz < 0) return r;
    gx = dx / cs;
    gz = dz / cs;
    if (gx >= pts - 1 || gz >= pts - 1) return r;
    fx = ((dx % cs) << 16) / cs;
    fz = ((dz % cs) << 16) / cs;
    tot = fx + fz;
    h00 = longint'($signed(height_grid[gx][gz]));
    h10 = longint'($signed(height_grid[gx + 1][gz]));
    h01 = longint'($signed(height_grid[gx][gz + 1]));
    h11 = longint'($signed(height_grid[gx + 1][gz + 1]));
    if (tot <= 65536) s = h00 * (65536 - tot) + h10 * fx + h01 * fz;
    else s = h10 * (65536 - fz) + h11 * (tot - 65536) + h01 * (65536 - fx);
    r.height = 32'((s + 32768) >>> 16);
    r.outside = 1'b0;
    r.gx = int'(gx);
    r.gz = int'(gz);
    return r;
  endfunction

  function automatic int next_gap();
    int k;
    k = $urandom_range(0, 99);
    if (no_gaps || k < 65) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] random_height();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Drives one transaction; called right after a falling edge.
  task automatic send_request(request_t it, bit typed_exp, answer_t typed);
    int gap;
    bit taken;
    lookup_t p;
    answer_t a;
    gap = next_gap();
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    req_type_i = it.req;
    query_x_i = it.qx;
    query_z_i = it.qz;
    write_col_i = it.col;
    write_row_i = it.row;
    write_height_i = it.h;
    do begin
      @(posedge clk_i);
      taken = !busy_o;
      if (taken) begin
        if (it.req == ReqWrite) begin
          height_grid[it.col][it.row] = it.h;
          loaded[it.col][it.row] = 1'b1;
        end else begin
          p = lookup_height(it.qx, it.qz);
          a.height = p.height;
          a.outside = p.outside;
          if (typed_exp) a = typed;
          pending_heights.insert(pending_heights.size(), a);
        end
      end
      @(negedge clk_i);
    end while (!taken);
  endtask

  task automatic write_register(reg_idx_e idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    case (idx)
      RegOriginX: origin_x_q = value;
      RegOriginZ: origin_z_q = value;
      RegCellSize: cell_size_q = value[30:0];
      RegPoints: points_q = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Waits until every query has answered and trailing writes have drained.
  task automatic drain();
    start_i = 1'b0;
    while (pending_heights.size() > 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Random query at a well-formed position inside the grid, or noise otherwise.
  task automatic random_query();
    request_t it;
    request_t w;
    answer_t none;
    lookup_t p;
    longint cs, pts, gx, gz, px, pz;
    none = '{default: '0};
    it = '{req: ReqQuery, qx: $urandom(), qz: $urandom(), col: $urandom(),
           row: $urandom(), h: $urandom()};
    cs = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
    pts = (points_q > GridPoints) ? GridPoints : longint'(points_q);
    if (pts >= 2 && $urandom_range(0, 99) < 80) begin
      gx = $urandom_range(0, int'(pts - 2));
      gz = $urandom_range(0, int'(pts - 2));
      if ($urandom_range(0, 3) == 0) gx = 0;
      if ($urandom_range(0, 3) == 0) gz = 0;
      px = longint'($signed(origin_x_q)) + gx * cs
           + (($urandom_range(0, 4) == 0) ? cs - 1 : longint'($urandom()) % cs);
      pz = longint'($signed(origin_z_q)) + gz * cs
           + (($urandom_range(0, 4) == 0) ? 0 : longint'($urandom()) % cs);
      if (px <= 64'sh7FFF_FFFF) it.qx = 32'(px);
      if (pz <= 64'sh7FFF_FFFF) it.qz = 32'(pz);
    end
    // Load any corner that the lookup would read before it was ever written.
    p = lookup_height(it.qx, it.qz);
    if (!p.outside) begin
      for (int dc = 0; dc < 2; dc++) begin
        for (int dr = 0; dr < 2; dr++) begin
          if (!loaded[p.gx + dc][p.gz + dr]) begin
            w = '{req: ReqWrite, qx: $urandom(), qz: $urandom(), col: 7'(p.gx + dc),
                  row: 7'(p.gz + dr), h: random_height()};
            send_request(w, 1'b0, none);
          end
        end
      end
    end
    send_request(it, 1'b0, none);
  endtask

  task automatic random_phase();
    request_t it;
    answer_t none;
    none = '{default: '0};
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < ItemsPerPhase; n++) begin
      if ($urandom_range(0, 99) < 25) begin
        it = '{req: ReqWrite, qx: $urandom(), qz: $urandom(), col: $urandom(),
               row: $urandom(), h: random_height()};
        send_request(it, 1'b0, none);
      end else begin
        random_query();
      end
    end
    no_gaps = 0;
  endtask

  // Result checker: every strobe is matched against the oldest expected answer.
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && strobe_o) begin
      if (pending_heights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: height %h outside %b", height_o, outside_o);
      end else begin
        e = pending_heights.pop_front();
        if (height_o !== e.height || outside_o !== e.outside) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected height %h outside %b, got height %h outside %b",
                     e.height, e.outside, height_o, outside_o);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction, result or register access.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || strobe_o || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    table_row_t dir_tab[18];
    setting_t settings[9];
    request_t it;
    answer_t typed;
    dir_tab = '{
      // Corner loads at the grid origin with extreme heights.
      '{ReqWrite, 32'h0, 32'h0, 7'd0, 7'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{ReqWrite, 32'h0, 32'h0, 7'd1, 7'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{ReqWrite, 32'h0, 32'h0, 7'd0, 7'd1, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{ReqWrite, 32'h0, 32'h0, 7'd1, 7'd1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      // Exactly on a grid point the corner height comes back; then points inside the first cell.
      '{ReqQuery, 32'h0, 32'h0, 7'd0, 7'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{ReqQuery, 32'h0000_FFFF, 32'h0, 7'd0, 7'd0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ReqQuery, 32'h0000_8000, 32'h0000_8000, 7'd0, 7'd0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ReqQuery, 32'h0000_C000, 32'h0000_C000, 7'd0, 7'd0, 32'h0, 1'b0, 32'h0, 1'b0},
      // Negative offsets and points beyond the grid are outside.
      '{ReqQuery, 32'hFFFF_FFFF, 32'h0, 7'd0, 7'd0, 32'h0, 1'b1, 32'h0, 1'b1},
      '{ReqQuery, 32'h0, 32'h8000_0000, 7'd0, 7'd0, 32'h0, 1'b1, 32'h0, 1'b1},
      '{ReqQuery, 32'h7FFF_FFFF, 32'h0, 7'd0, 7'd0, 32'h0, 1'b1, 32'h0, 1'b1},
      '{ReqQuery, 32'h007F_0000, 32'h0, 7'd0, 7'd0, 32'h0, 1'b1, 32'h0, 1'b1},
      // Far corner of the grid.
      '{ReqWrite, 32'h0, 32'h0, 7'd127, 7'd127, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{ReqWrite, 32'h0, 32'h0, 7'd126, 7'd126, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{ReqWrite, 32'h0, 32'h0, 7'd127, 7'd126, 32'h5555_5555, 1'b0, 32'h0, 1'b0},
      '{ReqWrite, 32'h0, 32'h0, 7'd126, 7'd127, 32'hAAAA_AAAA, 1'b0, 32'h0, 1'b0},
      '{ReqQuery, 32'h007E_FFFF, 32'h007E_FFFF, 7'd0, 7'd0, 32'h0, 1'b0, 32'h0, 1'b0},
      '{ReqQuery, 32'h007E_0000, 32'h007E_0000, 7'd0, 7'd0, 32'h0, 1'b1, 32'h8000_0000,
        1'b0}
    };
    // Settings to run through, extremes first.
    settings = '{
      '{32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'd2},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'd255},
      '{32'hFFC0_0000, 32'h0000_1000, 32'hFFFF_FFFF, 32'd128},
      '{32'h0, 32'h0, 32'h0001_0000, 32'd0},
      '{32'h0, 32'h0, 32'h0001_0000, 32'd1},
      '{32'hFFC0_0000, 32'hFFC0_0000, 32'h0001_0000, 32'd128},
      '{$urandom(), $urandom(), 32'h0000_3000, 32'd100},
      '{$urandom(), $urandom(), $urandom_range(1, 32'h0010_0000), $urandom_range(2, 129)},
      '{$urandom(), $urandom(), $urandom(), $urandom_range(0, 255)}
    };

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table under the reset configuration.
    foreach (dir_tab[i]) begin
      it = '{req: dir_tab[i].req, qx: dir_tab[i].qx, qz: dir_tab[i].qz,
             col: dir_tab[i].col, row: dir_tab[i].row, h: dir_tab[i].h};
      typed.height = dir_tab[i].exp_height;
      typed.outside = dir_tab[i].exp_outside;
      send_request(it, dir_tab[i].typed_exp, typed);
    end
    random_phase();

    // Random transactions under each setting.
    foreach (settings[i]) begin
      drain();
      write_register(RegOriginX, settings[i].ox);
      write_register(RegOriginZ, settings[i].oz);
      write_register(RegCellSize, settings[i].cs);
      write_register(RegPoints, settings[i].pts);
      random_phase();
    end

    // Back to the reset defaults for a last phase.
    drain();
    write_register(RegOriginX, 32'h0);
    write_register(RegOriginZ, 32'h0);
    write_register(RegCellSize, 32'h0001_0000);
    write_register(RegPoints, 32'd128);
    random_phase();
    drain();

    if (mismatches == 0 && pending_heights.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
